@@ sv/assert_macros.svh @@
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ sv/lkx_pkg.sv @@
// shared types and constants of the lcg keystream cipher
package lkx_pkg;

  localparam int WordW = 64;
  localparam int HalfW = 32;
  localparam int DataW = 8;
  localparam int AddrW = 5;
  localparam int CntW  = 6;
  localparam int StepW = 3;

  typedef enum logic [1:0] {
    REG_SEED = 2'd0,
    REG_MULT = 2'd1,
    REG_INC  = 2'd2,
    REG_MOD  = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_MOD  = 4'b0100,
    S_OUT  = 4'b1000
  } st_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

@@ sv/lkx_mul.sv @@
// iterative multiply-add on one 32x32 multiplier and one 64-bit adder
`include "assert_macros.svh"
module lkx_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lkx_pkg::WordW-1:0]   opa,
  input  logic [lkx_pkg::WordW-1:0]   opb,
  input  logic [lkx_pkg::WordW-1:0]   addc,
  output lkx_pkg::unit_sts_t          sts,
  output logic [lkx_pkg::WordW-1:0]   result
);
  import lkx_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [StepW-1:0] step_r;
  logic [WordW-1:0] prod_r;
  logic [WordW-1:0] acc_r;
  logic [WordW-1:0] acc_nxt;
  logic [HalfW-1:0] mul_a;
  logic [HalfW-1:0] mul_b;
  logic [WordW-1:0] prod_w;
  logic [WordW-1:0] base;
  logic [WordW-1:0] addend;

  always_comb begin
    mul_a  = opa[HalfW-1:0];
    mul_b  = opb[HalfW-1:0];
    base   = acc_r;
    addend = '0;
    case (step_r)
      3'd0: begin
      end
      3'd1: begin
        mul_b  = opb[WordW-1:HalfW];
        base   = '0;
        addend = prod_r;
      end
      3'd2: begin
        mul_a  = opa[WordW-1:HalfW];
        addend = {prod_r[HalfW-1:0], {HalfW{1'b0}}};
      end
      3'd3: begin
        addend = {prod_r[HalfW-1:0], {HalfW{1'b0}}};
      end
      3'd4: begin
        addend = addc;
      end
      default: begin
      end
    endcase
  end

  assign prod_w  = {{HalfW{1'b0}}, mul_a} * {{HalfW{1'b0}}, mul_b};
  assign acc_nxt = base + addend;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r <= 3'd2) begin
          prod_r <= prod_w;
        end
        if (step_r != 3'd0) begin
          acc_r <= acc_nxt;
        end
        if (step_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 3'd1;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign result   = acc_r;

  `ASSERT_RST(a_mul_no_restart, start |-> !busy_r, "multiply started while busy")
  `ASSERT_RST(a_mul_done_idle, done_r |-> !busy_r, "multiply done while still busy")
  `ASSERT_RST(a_mul_step_range, busy_r |-> (step_r <= 3'd4), "multiply step out of range")

endmodule

@@ sv/lkx_mod.sv @@
// restoring remainder unit, one quotient bit per cycle
`include "assert_macros.svh"
module lkx_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lkx_pkg::WordW-1:0]   dividend,
  input  logic [lkx_pkg::WordW-1:0]   divisor,
  output lkx_pkg::unit_sts_t          sts,
  output logic [lkx_pkg::WordW-1:0]   rem
);
  import lkx_pkg::*;

  logic            busy_r;
  logic            done_r;
  logic [CntW-1:0] cnt_r;
  logic [WordW-1:0] dvd_r;
  logic [WordW-1:0] div_r;
  logic [WordW-1:0] rem_r;
  logic [WordW-1:0] rem_nxt;
  logic [WordW:0]   trial;
  logic [WordW:0]   diff;
  logic             ge;

  assign trial   = {rem_r, dvd_r[WordW-1]};
  assign ge      = trial >= {1'b0, div_r};
  assign diff    = trial - {1'b0, div_r};
  assign rem_nxt = ge ? diff[WordW-1:0] : trial[WordW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(WordW - 1);
        rem_r  <= '0;
        dvd_r  <= dividend;
        div_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[WordW-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign rem      = rem_r;

  `ASSERT_RST(a_mod_no_restart, start |-> !busy_r, "remainder started while busy")
  `ASSERT_RST(a_mod_rem_bound, busy_r |-> (rem_r < div_r), "partial remainder not below divisor")
  `ASSERT_RST(a_mod_zero_div, start |-> (divisor != '0), "remainder started with zero divisor")

endmodule

@@ sv/lcg_keystream_xor_cipher.sv @@
// top level of the lcg keystream xor cipher
// Each byte taken on the in_ stream advances a 64-bit linear congruential
// generator, state = ((multiplier * state + increment) mod 2^64) mod modulus,
// and leaves as the byte xor the low byte of the new state (a modulus of zero
// skips the reduction). The multiply-add runs on one 32x32 multiplier and one
// 64-bit adder; the reduction runs on a restoring remainder unit at one bit
// per cycle. The next byte can be taken once the result word of the last
// byte has entered the output register, and in_tready is low while a byte
// is in work, from its acceptance until its result word is written. The
// result waits in an output register, so the next byte is accepted while the
// last result is still unread; a new result that finds that register still
// full holds the block until the word is taken. Writing the seed register
// (address 0) reloads the generator state; multiplier, increment and modulus
// lie at 8, 16 and 24.
`include "assert_macros.svh"
module lcg_keystream_xor_cipher (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [lkx_pkg::DataW-1:0]   in_tdata,   // data_byte
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [lkx_pkg::DataW-1:0]   out_tdata,  // cipher_byte
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [lkx_pkg::AddrW-1:0]   cfg_paddr,
  input  logic [lkx_pkg::WordW-1:0]   cfg_pwdata,
  output logic [lkx_pkg::WordW-1:0]   cfg_prdata,
  output logic                        cfg_pready
);
  import lkx_pkg::*;

  st_t              state_r;
  logic [WordW-1:0] seed_r;
  logic [WordW-1:0] mult_r;
  logic [WordW-1:0] inc_r;
  logic [WordW-1:0] modu_r;
  logic [WordW-1:0] gen_r;
  logic [WordW-1:0] newst_r;
  logic [DataW-1:0] data_r;
  logic             out_valid_r;
  logic [DataW-1:0] out_data_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;
  logic             in_acc;
  logic             mod_start;
  logic             out_free;
  unit_sts_t        mul_sts;
  unit_sts_t        mod_sts;
  logic [WordW-1:0] mul_res;
  logic [WordW-1:0] mod_res;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[AddrW-1:AddrW-2]);
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign mod_start  = (state_r == S_MUL) & mul_sts.done & (modu_r != '0);
  assign out_free   = !out_valid_r | out_tready;

  always_comb begin
    case (cfg_idx)
      REG_SEED: cfg_prdata = seed_r;
      REG_MULT: cfg_prdata = mult_r;
      REG_INC:  cfg_prdata = inc_r;
      REG_MOD:  cfg_prdata = modu_r;
      default:  cfg_prdata = '0;
    endcase
  end

  lkx_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_acc),
    .opa    (mult_r),
    .opb    (gen_r),
    .addc   (inc_r),
    .sts    (mul_sts),
    .result (mul_res)
  );

  lkx_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mul_res),
    .divisor  (modu_r),
    .sts      (mod_sts),
    .rem      (mod_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seed_r      <= '0;
      mult_r      <= WordW'(1);
      inc_r       <= '0;
      modu_r      <= WordW'(1);
      gen_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        case (cfg_idx)
          REG_SEED: begin
            seed_r <= cfg_pwdata;
            gen_r  <= cfg_pwdata;
          end
          REG_MULT: mult_r <= cfg_pwdata;
          REG_INC:  inc_r  <= cfg_pwdata;
          REG_MOD:  modu_r <= cfg_pwdata;
          default: begin
          end
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            data_r  <= in_tdata;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_sts.done) begin
            if (modu_r == '0) begin
              newst_r <= mul_res;
              state_r <= S_OUT;
            end else begin
              state_r <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (mod_sts.done) begin
            newst_r <= mod_res;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            gen_r       <= newst_r;
            out_data_r  <= data_r ^ newst_r[DataW-1:0];
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r), "not idle after reset")
  `ASSERT_RST(a_accept_mul, in_acc |=> (state_r == S_MUL && mul_sts.busy), "accepted word did not start multiply")
  `ASSERT_RST(a_mod_done_state, mod_sts.done |-> (state_r == S_MOD), "remainder done outside its state")
  `ASSERT_RST(a_seed_load, (cfg_wr && cfg_idx == REG_SEED) |=> (gen_r == $past(cfg_pwdata)), "seed write did not load state")

endmodule
